@@ hw/rtl/mbp_pkg.sv @@
// shared types, codes and helpers of the msb-first bit packer
package mbp_pkg;

   // default parameter values
   localparam int MAX_UNARY_DEF   = 255;
   localparam int COUNT_WIDTH_DEF = 48;
   localparam int QUEUE_DEPTH_DEF = 2;

   // fixed field widths
   localparam int VALUE_W = 64;
   localparam int NBITS_W = 7;
   localparam int BW_W    = 48;
   // remaining-bit counter covers a unary code of up to 1023 zeros plus its one
   localparam int JOB_LEN_W = 11;

   // request op codes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_UNARY = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_LEN   = 2'd1;
   localparam logic [1:0] ST_UNARY_BIG = 2'd2;

   localparam logic [NBITS_W-1:0] MAX_BITS = 7'd64;

   typedef struct packed {
      logic [1:0]         op;
      logic [NBITS_W-1:0] bit_count;
      logic [VALUE_W-1:0] value;
      logic               little_endian;
   } req_type;

   typedef struct packed {
      logic [7:0]      out_byte;
      logic            byte_valid;
      logic            last;
      logic [1:0]      status;
      logic [BW_W-1:0] bits_written;
   } rsp_type;

   typedef enum logic [1:0] {
      JOB_ERR,
      JOB_BITS,
      JOB_UNARY,
      JOB_FLUSH
   } job_kind_type;

   // classified work handed from front to back; bit fields are msb-aligned
   typedef struct packed {
      job_kind_type         kind;
      logic [VALUE_W-1:0]   data;
      logic [JOB_LEN_W-1:0] len;
      logic [1:0]           status;
      logic [BW_W-1:0]      total;
   } job_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

   // full 64-bit byte reversal
   function automatic logic [VALUE_W-1:0] bswap64(input logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         r[8*(7-i) +: 8] = v[8*i +: 8];
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/mbp_front.sv @@
// front end: accepts requests, checks lengths, keeps the bit total, queues jobs
module mbp_front #(
   parameter int MAX_UNARY   = mbp_pkg::MAX_UNARY_DEF,
   parameter int COUNT_WIDTH = mbp_pkg::COUNT_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mbp_pkg::req_type req_data,
   input  logic             q_full,
   output logic             q_push,
   output mbp_pkg::job_type q_job
);

   logic [COUNT_WIDTH-1:0] total_ff;
   logic [COUNT_WIDTH-1:0] total_in;
   logic                   keep;
   logic                   counts;
   logic                   accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept && keep;

   // classify the request into a job
   always_comb begin
      q_job        = '0;
      q_job.kind   = mbp_pkg::JOB_FLUSH;
      q_job.status = mbp_pkg::ST_OK;
      keep         = 1'b1;
      counts       = 1'b0;
      unique case (req_data.op)
         mbp_pkg::OP_WRITE: begin
            if (req_data.bit_count > mbp_pkg::MAX_BITS ||
                (req_data.little_endian && req_data.bit_count[2:0] != 3'd0)) begin
               q_job.kind   = mbp_pkg::JOB_ERR;
               q_job.status = mbp_pkg::ST_BAD_LEN;
            end else if (req_data.bit_count == '0) begin
               keep = 1'b0;
            end else begin
               q_job.kind = mbp_pkg::JOB_BITS;
               q_job.len  = mbp_pkg::JOB_LEN_W'(req_data.bit_count);
               counts     = 1'b1;
               if (req_data.little_endian) begin
                  q_job.data = mbp_pkg::bswap64(req_data.value) &
                               ~({mbp_pkg::VALUE_W{1'b1}} >> req_data.bit_count);
               end else begin
                  q_job.data = req_data.value << (mbp_pkg::MAX_BITS - req_data.bit_count);
               end
            end
         end
         mbp_pkg::OP_UNARY: begin
            if (req_data.value > 64'(MAX_UNARY)) begin
               q_job.kind   = mbp_pkg::JOB_ERR;
               q_job.status = mbp_pkg::ST_UNARY_BIG;
            end else begin
               q_job.kind = mbp_pkg::JOB_UNARY;
               q_job.len  = mbp_pkg::JOB_LEN_W'(req_data.value[mbp_pkg::JOB_LEN_W-2:0]) +
                            mbp_pkg::JOB_LEN_W'(1);
               counts     = 1'b1;
            end
         end
         mbp_pkg::OP_FLUSH: begin
            q_job.kind = mbp_pkg::JOB_FLUSH;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      total_in    = counts ? total_ff + COUNT_WIDTH'(q_job.len) : total_ff;
      q_job.total = mbp_pkg::BW_W'(total_in);
   end

   // running bit total
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (q_push) begin
         total_ff <= total_in;
      end
   end

endmodule

@@ hw/rtl/mbp_queue.sv @@
// small job fifo between front and back
module mbp_queue #(
   parameter int DEPTH = mbp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mbp_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output mbp_pkg::job_type pop_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mbp_pkg::job_type   mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_job   = mem[rd_ptr_ff];

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

@@ hw/rtl/mbp_back.sv @@
// back end: shifts job bits into the partial byte and emits one byte per cycle while the output slot is free
module mbp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_pop,
   input  mbp_pkg::job_type q_job,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mbp_pkg::rsp_type rsp_data
);

   localparam int LW = mbp_pkg::JOB_LEN_W;

   mbp_pkg::back_state_type state_ff, state_in;
   mbp_pkg::job_kind_type   kind_ff, kind_in;
   logic [mbp_pkg::VALUE_W-1:0] data_ff, data_in;
   logic [LW-1:0]               rem_ff, rem_in;
   logic [1:0]                  status_ff, status_in;
   logic [mbp_pkg::BW_W-1:0]    total_ff, total_in;
   logic [7:0]                  partial_ff, partial_in;
   logic [2:0]                  fill_ff, fill_in;
   mbp_pkg::rsp_type            rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic       slot_free;
   logic       done;
   logic [3:0] take;
   logic [7:0] top8;
   logic [7:0] merged;
   logic [LW-1:0] rest;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // window of the next bits and the byte they complete
   always_comb begin
      take = 4'd8 - {1'b0, fill_ff};
      if (kind_ff == mbp_pkg::JOB_UNARY) begin
         top8 = (rem_ff <= LW'(8)) ? (8'h80 >> 3'(rem_ff[2:0] - 3'd1)) : 8'h00;
      end else begin
         top8 = data_ff[mbp_pkg::VALUE_W-1 -: 8];
      end
      merged = partial_ff | (top8 >> fill_ff);
      rest   = rem_ff - LW'(take);
   end

   // datapath and outputs
   always_comb begin
      kind_in      = kind_ff;
      data_in      = data_ff;
      rem_in       = rem_ff;
      status_in    = status_ff;
      total_in     = total_ff;
      partial_in   = partial_ff;
      fill_in      = fill_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_pop        = 1'b0;
      done         = 1'b0;
      unique case (state_ff)
         mbp_pkg::BACK_IDLE: begin
            q_pop     = q_valid;
            kind_in   = q_job.kind;
            data_in   = q_job.data;
            rem_in    = q_job.len;
            status_in = q_job.status;
            total_in  = q_job.total;
         end
         mbp_pkg::BACK_RUN: begin
            if (slot_free) begin
               unique case (kind_ff)
                  mbp_pkg::JOB_ERR: begin
                     rsp_valid_in        = 1'b1;
                     rsp_in.out_byte     = 8'h00;
                     rsp_in.byte_valid   = 1'b0;
                     rsp_in.last         = 1'b1;
                     rsp_in.status       = status_ff;
                     rsp_in.bits_written = total_ff;
                     done                = 1'b1;
                  end
                  mbp_pkg::JOB_FLUSH: begin
                     if (fill_ff != 3'd0) begin
                        rsp_valid_in        = 1'b1;
                        rsp_in.out_byte     = partial_ff;
                        rsp_in.byte_valid   = 1'b1;
                        rsp_in.last         = 1'b1;
                        rsp_in.status       = mbp_pkg::ST_OK;
                        rsp_in.bits_written = total_ff;
                     end
                     partial_in = 8'h00;
                     fill_in    = 3'd0;
                     done       = 1'b1;
                  end
                  mbp_pkg::JOB_BITS, mbp_pkg::JOB_UNARY: begin
                     if (rem_ff >= LW'(take)) begin
                        // byte completes; last when fewer than eight bits stay behind
                        rsp_valid_in        = 1'b1;
                        rsp_in.out_byte     = merged;
                        rsp_in.byte_valid   = 1'b1;
                        rsp_in.last         = (rest < LW'(8));
                        rsp_in.status       = mbp_pkg::ST_OK;
                        rsp_in.bits_written = total_ff;
                        partial_in          = 8'h00;
                        fill_in             = 3'd0;
                        data_in             = data_ff << take;
                        rem_in              = rest;
                        done                = (rest == '0);
                     end else begin
                        // leftover bits stay in the partial byte
                        partial_in = merged;
                        fill_in    = fill_ff + rem_ff[2:0];
                        rem_in     = '0;
                        done       = 1'b1;
                     end
                  end
               endcase
            end
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbp_pkg::BACK_IDLE: begin
            if (q_valid) begin
               state_in = mbp_pkg::BACK_RUN;
            end
         end
         mbp_pkg::BACK_RUN: begin
            if (done) begin
               state_in = mbp_pkg::BACK_IDLE;
            end
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbp_pkg::BACK_IDLE;
         partial_ff   <= 8'h00;
         fill_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         partial_ff   <= partial_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // job and response payload
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      data_ff   <= data_in;
      rem_ff    <= rem_in;
      status_ff <= status_in;
      total_ff  <= total_in;
      rsp_ff    <= rsp_in;
   end

endmodule

@@ hw/rtl/msb_first_bit_packer.sv @@
// top level of the msb-first bit packer
//
// Packs fields msb-first into a byte stream. A request (req_valid/req_ready,
// payload req_data) writes the low bit_count bits of value, optionally byte
// reversed, writes a unary code (value zeros then a one), or flushes a
// pending partial byte zero-padded. Each completed byte is one response on
// rsp_valid/rsp_ready; the final response of a request has last set, and a
// bad length gives one error response with byte_valid low.
// The front end classifies a request in the cycle it is accepted and parks
// it in a QUEUE_DEPTH-entry job queue. The back end loads one job at a time
// and then emits one byte per cycle into its output register while rsp_ready
// does not stall it. A job holds the back end for a load step, one step per
// output byte and one more when bits stay behind in the partial byte.
// A stall on rsp_ready holds the output register and the back end; the
// front keeps taking requests until the queue fills. Reset empties the
// queue, clears the partial byte and sets the bit total to zero.
module msb_first_bit_packer #(
   parameter int MAX_UNARY   = mbp_pkg::MAX_UNARY_DEF,
   parameter int COUNT_WIDTH = mbp_pkg::COUNT_WIDTH_DEF,
   parameter int QUEUE_DEPTH = mbp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mbp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mbp_pkg::rsp_type rsp_data
);

   logic             q_push;
   logic             q_full;
   logic             q_pop;
   logic             q_not_empty;
   mbp_pkg::job_type push_job;
   mbp_pkg::job_type pop_job;

   // request classification
   mbp_front #(
      .MAX_UNARY   (MAX_UNARY),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   // job queue
   mbp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_job   (pop_job)
   );

   // byte assembly
   mbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_pop     (q_pop),
      .q_job     (pop_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the msb-first bit packer
module tb;

   // op code with no meaning to the packer
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int UNARY_LIMIT  = mbp_pkg::MAX_UNARY_DEF;
   localparam int RANDOM_COUNT = 446;
   localparam int STALL_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AFTER   = 140;
   localparam int PAUSE_AT     = 330;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      mbp_pkg::req_type req;
      bit               typed;
      mbp_pkg::rsp_type want;
   } stim_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   mbp_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   mbp_pkg::rsp_type rsp_data;

   // packer state as the testbench sees it
   logic [7:0]               model_byte;
   logic [3:0]               model_free;
   logic [mbp_pkg::BW_W-1:0] model_total;
   logic [7:0]               model_bytes[$];
   mbp_pkg::rsp_type         step_rsp[$];

   // responses still owed by the block, oldest first
   mbp_pkg::rsp_type packed_due[$];
   stim_row_type     directed[$];

   int failures;
   int rsp_checked;
   int err_seen;
   int reqs_accepted;
   int burst_left;
   int op_seen[4];

   msb_first_bit_packer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   function automatic mbp_pkg::rsp_type make_rsp(input logic [7:0] b, input logic v,
                                                 input logic l, input logic [1:0] st,
                                                 input logic [mbp_pkg::BW_W-1:0] bw);
      mbp_pkg::rsp_type r;
      r.out_byte     = b;
      r.byte_valid   = v;
      r.last         = l;
      r.status       = st;
      r.bits_written = bw;
      return r;
   endfunction

   function automatic mbp_pkg::req_type make_req(input logic [1:0] op, input logic [6:0] cnt,
                                                 input logic [63:0] val, input logic le);
      mbp_pkg::req_type r;
      r.op            = op;
      r.bit_count     = cnt;
      r.value         = val;
      r.little_endian = le;
      return r;
   endfunction

   function automatic void add_row(input mbp_pkg::req_type r, input bit typed,
                                   input mbp_pkg::rsp_type want);
      stim_row_type row;
      row.req   = r;
      row.typed = typed;
      row.want  = want;
      directed.push_back(row);
   endfunction

   // append one bit msb-first to the byte being filled
   function automatic void shift_in(input logic b);
      model_free = model_free - 4'd1;
      if (b) model_byte[model_free[2:0]] = 1'b1;
      if (model_free == 4'd0) begin
         model_bytes.push_back(model_byte);
         model_byte = '0;
         model_free = 4'd8;
      end
      model_total = model_total + 1'b1;
   endfunction

   // low n bytes of v in reverse order
   function automatic logic [63:0] reverse_bytes(input logic [63:0] v, input int n);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < n; i++) r = {r[55:0], v[8*i +: 8]};
      return r;
   endfunction

   // responses caused by one request, left in step_rsp
   function automatic void pack_request(input mbp_pkg::req_type r);
      logic [63:0] v;
      int          n;
      step_rsp.delete();
      model_bytes.delete();
      case (r.op)
         mbp_pkg::OP_WRITE: begin
            if (r.bit_count > mbp_pkg::MAX_BITS ||
                (r.little_endian && r.bit_count[2:0] != 3'd0)) begin
               step_rsp.push_back(make_rsp(8'h00, 1'b0, 1'b1, mbp_pkg::ST_BAD_LEN,
                                           model_total));
               return;
            end
            n = int'(r.bit_count);
            v = r.little_endian ? reverse_bytes(r.value, n / 8) : r.value;
            for (int i = n - 1; i >= 0; i--) shift_in(v[i]);
         end
         mbp_pkg::OP_UNARY: begin
            if (r.value > 64'(UNARY_LIMIT)) begin
               step_rsp.push_back(make_rsp(8'h00, 1'b0, 1'b1, mbp_pkg::ST_UNARY_BIG,
                                           model_total));
               return;
            end
            n = int'(r.value[9:0]);
            repeat (n) shift_in(1'b0);
            shift_in(1'b1);
         end
         mbp_pkg::OP_FLUSH: begin
            // pending bits go out zero-padded, padding is not counted
            if (model_free != 4'd8) model_bytes.push_back(model_byte);
            model_byte = '0;
            model_free = 4'd8;
         end
         default: ;
      endcase
      foreach (model_bytes[k])
         step_rsp.push_back(make_rsp(model_bytes[k], 1'b1, k == model_bytes.size() - 1,
                                     mbp_pkg::ST_OK, model_total));
   endfunction

   function automatic mbp_pkg::req_type random_request();
      mbp_pkg::req_type r;
      int               pick;
      pick            = $urandom_range(0, 99);
      r.op            = mbp_pkg::OP_WRITE;
      r.value         = {$urandom(), $urandom()};
      r.little_endian = ($urandom_range(0, 3) == 0);
      r.bit_count     = 7'($urandom_range(0, 64));
      if (pick < 50) begin
         // byte reversal mostly gets whole bytes
         if (r.little_endian && $urandom_range(0, 7) != 0) r.bit_count[2:0] = 3'd0;
      end else if (pick < 58) begin
         r.bit_count = 7'd64;
      end else if (pick < 61) begin
         r.bit_count = 7'($urandom_range(65, 127));
      end else if (pick < 82) begin
         r.op = mbp_pkg::OP_UNARY;
         case ($urandom_range(0, 9))
            0: r.value = 64'($urandom_range(UNARY_LIMIT - 8, UNARY_LIMIT));
            1: ;
            2: r.value = 64'($urandom_range(UNARY_LIMIT + 1, 1023));
            default: r.value = 64'($urandom_range(0, 24));
         endcase
      end else if (pick < 95) begin
         r.op = mbp_pkg::OP_FLUSH;
      end else begin
         r.op = OP_UNUSED;
      end
      return r;
   endfunction

   // offer one request in the current burst, then record what it owes
   task automatic offer(input stim_row_type row);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= row.req;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      reqs_accepted++;
      op_seen[row.req.op]++;
      pack_request(row.req);
      if (row.typed) packed_due.push_back(row.want);
      else foreach (step_rsp[k]) packed_due.push_back(step_rsp[k]);
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side stalls on its own pattern, with one long hold-off
   initial begin : receiver
      int mode;
      int span;
      bit held;
      rsp_ready = 1'b0;
      held      = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(4, 48);
         repeat (span) begin
            @(posedge clock);
            if (!held && reqs_accepted >= HOLD_AFTER) begin
               held = 1'b1;
               rsp_ready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
            end
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= $urandom_range(0, 1);
               default: rsp_ready <= ($urandom_range(0, 5) == 0);
            endcase
         end
      end
   end

   // compare each accepted response with the oldest expectation
   always @(posedge clock) begin : check_rsp
      mbp_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_checked++;
         if (packed_due.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected response: byte %02h valid %0b last %0b status %0d count %0d",
                        rsp_data.out_byte, rsp_data.byte_valid, rsp_data.last,
                        rsp_data.status, rsp_data.bits_written);
         end else begin
            want = packed_due.pop_front();
            if (!want.byte_valid) err_seen++;
            if (rsp_data.out_byte !== want.out_byte || rsp_data.byte_valid !== want.byte_valid ||
                rsp_data.last !== want.last || rsp_data.status !== want.status ||
                rsp_data.bits_written !== want.bits_written) begin
               failures++;
               if (failures <= 10)
                  $display({"mismatch on response %0d: expected byte %02h valid %0b last %0b ",
                            "status %0d count %0d, got byte %02h valid %0b last %0b ",
                            "status %0d count %0d"},
                           rsp_checked, want.out_byte, want.byte_valid, want.last,
                           want.status, want.bits_written, rsp_data.out_byte,
                           rsp_data.byte_valid, rsp_data.last, rsp_data.status,
                           rsp_data.bits_written);
            end
         end
      end
   end

   // end the run when neither channel moves for too long
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
         else idle++;
      end
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // stimulus: directed rows, then random requests
   initial begin : stimulus
      stim_row_type row;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      model_byte  = '0;
      model_free  = 4'd8;
      model_total = '0;
      burst_left  = 0;

      // first byte after reset, full-width writes in both byte orders
      add_row(make_req(mbp_pkg::OP_WRITE, 7'd8, 64'hA5, 1'b0), 1'b1,
              make_rsp(8'hA5, 1'b1, 1'b1, mbp_pkg::ST_OK, 48'd8));
      add_row(make_req(mbp_pkg::OP_WRITE, 7'd64, 64'h0123_4567_89AB_CDEF, 1'b0), 1'b0, '0);
      add_row(make_req(mbp_pkg::OP_WRITE, 7'd64, 64'h0123_4567_89AB_CDEF, 1'b1), 1'b0, '0);
      // zero-length write and the bad lengths
      add_row(make_req(mbp_pkg::OP_WRITE, 7'd0, '1, 1'b0), 1'b0, '0);
      add_row(make_req(mbp_pkg::OP_WRITE, 7'd65, 64'h1, 1'b0), 1'b1,
              make_rsp(8'h00, 1'b0, 1'b1, mbp_pkg::ST_BAD_LEN, 48'd136));
      add_row(make_req(mbp_pkg::OP_WRITE, 7'd127, '1, 1'b1), 1'b1,
              make_rsp(8'h00, 1'b0, 1'b1, mbp_pkg::ST_BAD_LEN, 48'd136));
      add_row(make_req(mbp_pkg::OP_WRITE, 7'd12, 64'hABC, 1'b1), 1'b1,
              make_rsp(8'h00, 1'b0, 1'b1, mbp_pkg::ST_BAD_LEN, 48'd136));
      // partial byte, then flush with and without pending bits
      add_row(make_req(mbp_pkg::OP_WRITE, 7'd3, 64'h5, 1'b0), 1'b0, '0);
      add_row(make_req(mbp_pkg::OP_FLUSH, 7'd0, '0, 1'b0), 1'b1,
              make_rsp(8'hA0, 1'b1, 1'b1, mbp_pkg::ST_OK, 48'd139));
      add_row(make_req(mbp_pkg::OP_FLUSH, 7'd0, '0, 1'b0), 1'b0, '0);
      // unary codes: shortest, too long, longest
      add_row(make_req(mbp_pkg::OP_UNARY, 7'd0, 64'd0, 1'b0), 1'b0, '0);
      add_row(make_req(mbp_pkg::OP_UNARY, 7'd0, 64'd256, 1'b0), 1'b1,
              make_rsp(8'h00, 1'b0, 1'b1, mbp_pkg::ST_UNARY_BIG, 48'd140));
      add_row(make_req(mbp_pkg::OP_UNARY, '1, '1, 1'b1), 1'b1,
              make_rsp(8'h00, 1'b0, 1'b1, mbp_pkg::ST_UNARY_BIG, 48'd140));
      add_row(make_req(mbp_pkg::OP_UNARY, 7'd0, 64'd255, 1'b0), 1'b0, '0);
      // unknown op is ignored
      add_row(make_req(OP_UNUSED, '1, '1, 1'b1), 1'b0, '0);
      add_row(make_req(mbp_pkg::OP_WRITE, 7'd1, 64'h1, 1'b0), 1'b0, '0);
      add_row(make_req(mbp_pkg::OP_WRITE, 7'd64, '1, 1'b1), 1'b0, '0);
      add_row(make_req(mbp_pkg::OP_WRITE, 7'd64, '0, 1'b0), 1'b0, '0);
      add_row(make_req(mbp_pkg::OP_WRITE, 7'd0, 64'h1234, 1'b1), 1'b0, '0);
      add_row(make_req(mbp_pkg::OP_WRITE, 7'd7, 64'hFFFF_FFFF_FFFF_FF80, 1'b0), 1'b0, '0);
      add_row(make_req(mbp_pkg::OP_WRITE, 7'd64, 64'h8000_0000_0000_0001, 1'b0), 1'b0, '0);
      add_row(make_req(mbp_pkg::OP_WRITE, 7'd16, 64'h1234, 1'b1), 1'b0, '0);
      add_row(make_req(mbp_pkg::OP_FLUSH, 7'd0, '1, 1'b1), 1'b0, '0);
      add_row(make_req(mbp_pkg::OP_UNARY, 7'd0, 64'd7, 1'b0), 1'b0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) offer(directed[i]);

      for (int i = 0; i < RANDOM_COUNT; i++) begin
         // one pause until the block has drained
         if (i == PAUSE_AT) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (packed_due.size() != 0) @(posedge clock);
            burst_left = 0;
         end
         row.req   = random_request();
         row.typed = 1'b0;
         row.want  = '0;
         offer(row);
      end

      // drain
      req_valid <= 1'b0;
      while (packed_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (packed_due.size() != 0) begin
         failures += packed_due.size();
         $display("%0d expected responses never arrived", packed_due.size());
      end
      $display("run covered %0d requests: %0d writes, %0d unary codes, %0d flushes, %0d ignored",
               reqs_accepted, op_seen[mbp_pkg::OP_WRITE], op_seen[mbp_pkg::OP_UNARY],
               op_seen[mbp_pkg::OP_FLUSH], op_seen[OP_UNUSED]);
      $display("%0d responses checked, %0d of them errors, %0d failures",
               rsp_checked, err_seen, failures);
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/mbp_pkg.sv
hw/rtl/mbp_front.sv
hw/rtl/mbp_queue.sv
hw/rtl/mbp_back.sv
hw/rtl/msb_first_bit_packer.sv
verif/tb.sv
